// ===== rtl/core/wac_pkg.sv =====
// Shared types and constants of the wall avoidance controller.
package wac_pkg;

  // Default number of readings reduced into one proximity value.
  localparam int unsigned BufferDepthDefault = 8;

  // Width of the reduced proximity values and the block accumulator.
  localparam int unsigned ProxW = 16;
  localparam int unsigned ReadingW = 10;
  localparam int unsigned TimeW = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_READING = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } wac_func_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_INIT   = 2'd1,
    ST_ROTATE = 2'd2,
    ST_ESCAPE = 2'd3
  } wac_state_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } wac_dir_e;

  typedef enum logic [1:0] {
    MOV_NONE     = 2'd0,
    MOV_LEFT     = 2'd1,
    MOV_RIGHT    = 2'd2,
    MOV_STRAIGHT = 2'd3
  } wac_motion_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REDUCE_MODE     = 2'd0,
    CFG_DETECT_TIMEOUT  = 2'd1,
    CFG_ROTATE_TIMEOUT  = 2'd2,
    CFG_UNUSED          = 2'd3
  } wac_cfg_e;

  // Commands from the controller to the proximity reducer.
  typedef struct packed {
    logic                take;      // fold one reading into the block
    logic                clear;     // drop the block and both proximity values
    logic                fresh_clr; // consume the fresh flag
    logic                max_mode;  // 1 takes the maximum, 0 sums
    logic [ReadingW-1:0] reading;
  } wac_prox_ctrl_t;

  // Proximity values seen by the controller.
  typedef struct packed {
    logic [ProxW-1:0] current;
    logic [ProxW-1:0] previous;
    logic             fresh;
  } wac_prox_stat_t;

endpackage

// ===== rtl/core/wac_prox.sv =====
// Block reducer: gathers readings into blocks and keeps the last two results.
module wac_prox #(
  parameter int unsigned BufferDepth = wac_pkg::BufferDepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wac_pkg::wac_prox_ctrl_t ctrl_i,
  output wac_pkg::wac_prox_stat_t stat_o
);
  import wac_pkg::*;

  localparam int unsigned CountW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam logic [CountW-1:0] LastCount = CountW'(BufferDepth - 1);

  logic [CountW-1:0] count_q, count_d;
  logic [ProxW-1:0]  accum_q, accum_d;
  logic [ProxW-1:0]  cur_q, cur_d;
  logic [ProxW-1:0]  prev_q, prev_d;
  logic              fresh_q, fresh_d;
  logic [ProxW-1:0]  reading_ext;
  logic [ProxW-1:0]  folded;

  assign reading_ext = ProxW'(ctrl_i.reading);

  always_comb begin
    if (ctrl_i.max_mode) begin
      folded = (reading_ext > accum_q) ? reading_ext : accum_q;
    end else begin
      folded = accum_q + reading_ext;
    end
  end

  always_comb begin
    count_d = count_q;
    accum_d = accum_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    fresh_d = fresh_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      accum_d = '0;
      cur_d   = '0;
      prev_d  = '0;
    end else if (ctrl_i.take) begin
      if (count_q == LastCount) begin
        // The block is complete: shift the result in and start over.
        prev_d  = cur_q;
        cur_d   = folded;
        accum_d = '0;
        count_d = '0;
        fresh_d = 1'b1;
      end else begin
        accum_d = folded;
        count_d = count_q + CountW'(1);
      end
    end
    if (ctrl_i.fresh_clr) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      accum_q <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      count_q <= count_d;
      accum_q <= accum_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      fresh_q <= fresh_d;
    end
  end

  assign stat_o.current  = cur_q;
  assign stat_o.previous = prev_q;
  assign stat_o.fresh    = fresh_q;

endmodule

// ===== rtl/core/wall_avoidance_controller.sv =====
// Top level of the wall avoidance controller: input register, state machine, result register.
//
// The controller takes one word per cycle and returns exactly one result word
// for each, in order. An accepted word sits in an input register until it
// can move on; in the cycle it leaves, the tick state machine and the
// proximity reducer update and the result is captured in the output
// register, so the throughput is one word per clock as long as the
// result side keeps taking words. Both sides decouple through these registers:
// a new word is taken while a finished result still waits, and only a stall
// with both registers full holds off the input. Ticks (func 0) run the
// idle/init/rotate/escape machine and report a motion command; wall readings
// (func 1) refresh the detection deadline and feed a block of BufferDepth
// samples that is reduced to a sum (wrapping at 16 bits) or a maximum; a
// restart (func 2) forces the init state; func 3 changes nothing. The active
// bit reports whether a wall is still considered seen after the word. Deadline
// arithmetic wraps at 32 bits and the compare is a plain unsigned one.
// Configuration writes take effect at once and are meant to be made only while
// no word is in flight.
module wall_avoidance_controller #(
  parameter int unsigned BufferDepth = wac_pkg::BufferDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [wac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wac_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [wac_pkg::TimeW-1:0]     now_i,
  input  logic [wac_pkg::ReadingW-1:0]  reading_i,
  input  logic                          coin_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          active_o,
  output logic [1:0]                    motion_o
);
  import wac_pkg::*;

  // Configuration registers.
  logic                reduce_mode_q;
  logic [TimeoutW-1:0] detect_to_q;
  logic [TimeoutW-1:0] rotate_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_mode_q <= 1'b0;
      detect_to_q   <= TimeoutW'(32);
      rotate_to_q   <= TimeoutW'(240);
    end else if (cfg_we_i) begin
      case (wac_cfg_e'(cfg_idx_i))
        CFG_REDUCE_MODE:    reduce_mode_q <= cfg_wdata_i[0];
        CFG_DETECT_TIMEOUT: detect_to_q   <= cfg_wdata_i[TimeoutW-1:0];
        CFG_ROTATE_TIMEOUT: rotate_to_q   <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. The word held here is processed in the cycle it moves
  // on into the result register.
  logic                s1_valid_q;
  logic [1:0]          s1_func_q;
  logic [TimeW-1:0]    s1_now_q;
  logic [ReadingW-1:0] s1_reading_q;
  logic                s1_coin_q;
  logic                advance;

  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q    <= func_i;
      s1_now_q     <= now_i;
      s1_reading_q <= reading_i;
      s1_coin_q    <= coin_i;
    end
  end

  // Controller state.
  wac_state_e       state_q, state_d;
  wac_dir_e         dir_q, dir_d;
  logic             seen_q, seen_d;
  logic [TimeW-1:0] det_dl_q, det_dl_d;
  logic [TimeW-1:0] rot_dl_q, rot_dl_d;

  wac_prox_ctrl_t   prox_ctrl;
  wac_prox_stat_t   prox_stat;
  wac_motion_e      motion;

  logic [TimeW-1:0] det_sum;
  logic [TimeW-1:0] rot_sum;
  logic             det_expired;
  logic             rot_expired;

  assign det_sum     = s1_now_q + TimeW'(detect_to_q);
  assign rot_sum     = s1_now_q + TimeW'(rotate_to_q);
  assign det_expired = s1_now_q > det_dl_q;
  assign rot_expired = s1_now_q > rot_dl_q;

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    seen_d    = seen_q;
    det_dl_d  = det_dl_q;
    rot_dl_d  = rot_dl_q;
    motion    = MOV_NONE;
    prox_ctrl = '{take: 1'b0, clear: 1'b0, fresh_clr: 1'b0,
                  max_mode: reduce_mode_q, reading: s1_reading_q};
    if (advance) begin
      case (wac_func_e'(s1_func_q))
        FUNC_TICK: begin
          if (det_expired) begin
            // The detection window has run out: stand down.
            seen_d  = 1'b0;
            dir_d   = DIR_NONE;
            state_d = ST_IDLE;
          end else if (seen_q) begin
            case (state_q)
              ST_ROTATE: begin
                if (rot_expired) begin
                  rot_dl_d        = rot_sum;
                  prox_ctrl.clear = 1'b1;
                  if (dir_q == DIR_LEFT) begin
                    dir_d  = DIR_RIGHT;
                    motion = MOV_RIGHT;
                  end else begin
                    dir_d  = DIR_LEFT;
                    motion = MOV_LEFT;
                  end
                end
                if (prox_stat.fresh) begin
                  prox_ctrl.fresh_clr = 1'b1;
                  // After a reversal both values are cleared, so no escape.
                  if (!rot_expired && (prox_stat.previous > prox_stat.current)) begin
                    motion  = MOV_STRAIGHT;
                    state_d = ST_ESCAPE;
                  end
                end
              end
              ST_ESCAPE: begin
                if (prox_stat.fresh) begin
                  prox_ctrl.fresh_clr = 1'b1;
                  if (prox_stat.previous < prox_stat.current) begin
                    state_d = ST_INIT;
                  end
                end
              end
              default: begin
                // Idle and init both pick a fresh turn direction.
                if (s1_coin_q) begin
                  dir_d  = DIR_LEFT;
                  motion = MOV_LEFT;
                end else begin
                  dir_d  = DIR_RIGHT;
                  motion = MOV_RIGHT;
                end
                prox_ctrl.clear = 1'b1;
                rot_dl_d        = rot_sum;
                state_d         = ST_ROTATE;
              end
            endcase
          end
        end
        FUNC_READING: begin
          seen_d         = 1'b1;
          det_dl_d       = det_sum;
          prox_ctrl.take = 1'b1;
        end
        FUNC_RESTART: begin
          dir_d   = DIR_NONE;
          state_d = ST_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dir_q    <= DIR_NONE;
      seen_q   <= 1'b0;
      det_dl_q <= '0;
      rot_dl_q <= '0;
    end else begin
      state_q  <= state_d;
      dir_q    <= dir_d;
      seen_q   <= seen_d;
      det_dl_q <= det_dl_d;
      rot_dl_q <= rot_dl_d;
    end
  end

  wac_prox #(
    .BufferDepth(BufferDepth)
  ) u_prox (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (prox_ctrl),
    .stat_o (prox_stat)
  );

  // Result register.
  logic       out_valid_q;
  logic       active_q;
  logic [1:0] motion_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      active_q <= seen_d;
      motion_q <= motion;
    end
  end

  assign out_valid_o = out_valid_q;
  assign active_o    = active_q;
  assign motion_o    = motion_q;

endmodule

// ===== bench/wall_avoidance_controller_test.sv =====
// Self-checking testbench for the wall avoidance controller: random and directed words.
module wall_avoidance_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wac_pkg::*;

  localparam int unsigned BlockLen     = BufferDepthDefault;
  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned LimitCycles  = 200000;
  localparam int unsigned PhaseWords   = 65;

  // One input word and the result word it should produce.
  typedef struct {
    wac_func_e            func;
    logic [TimeW-1:0]     now;
    logic [ReadingW-1:0]  reading;
    logic                 coin;
  } sensor_word_t;

  typedef struct {
    logic        active;
    wac_motion_e motion;
  } steer_cmd_t;

  // Clock, reset and every block input start at known values.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic [1:0]           func_i      = '0;
  logic [TimeW-1:0]     now_i       = '0;
  logic [ReadingW-1:0]  reading_i   = '0;
  logic                 coin_i      = 1'b0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 active_o;
  logic [1:0]           motion_o;

  wall_avoidance_controller #(
    .BufferDepth (BlockLen)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .now_i       (now_i),
    .reading_i   (reading_i),
    .coin_i      (coin_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .active_o    (active_o),
    .motion_o    (motion_o)
  );

  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  // Words waiting to be offered, and the commands predicted for accepted words.
  sensor_word_t word_q[$];
  steer_cmd_t   command_q[$];

  int unsigned send_idle  = 13;
  int unsigned recv_idle  = 72;
  int unsigned hold_id    = 0;
  int unsigned mismatches = 0;

  // Our own copy of the controller: configuration first, then its state.
  logic                 cfg_max_mode  = 1'b0;
  logic [TimeoutW-1:0]  cfg_detect_to = 16'd32;
  logic [TimeoutW-1:0]  cfg_rotate_to = 16'd240;

  wac_state_e           ctl_state  = ST_IDLE;
  wac_dir_e             heading    = DIR_NONE;
  logic                 wall_live  = 1'b0;
  logic [TimeW-1:0]     detect_due = '0;
  logic [TimeW-1:0]     rotate_due = '0;
  logic [6:0]           blk_cnt    = '0;
  logic [ProxW-1:0]     blk_acc    = '0;
  logic [ProxW-1:0]     prox_now   = '0;
  logic [ProxW-1:0]     prox_prev  = '0;
  logic                 prox_new   = 1'b0;

  // State of the word generator: a running clock and the level of the current block.
  logic [TimeW-1:0]     gen_time  = '0;
  int unsigned          gen_level = 0;
  int unsigned          gen_reads = 0;

  // Dropping the block and both proximity values leaves the fresh flag alone.
  function automatic void drop_proximity();
    blk_cnt   = '0;
    blk_acc   = '0;
    prox_now  = '0;
    prox_prev = '0;
  endfunction

  // Advances the controller copy by one accepted word and returns its command.
  function automatic steer_cmd_t next_command(sensor_word_t w);
    steer_cmd_t c;
    c.motion = MOV_NONE;
    case (w.func)
      FUNC_TICK: begin
        // The deadline compare is a plain unsigned one, so a wrapped deadline
        // expires at once.
        if (w.now > detect_due) begin
          wall_live = 1'b0;
          heading   = DIR_NONE;
          ctl_state = ST_IDLE;
        end
        if (wall_live) begin
          case (ctl_state)
            ST_ROTATE: begin
              if (w.now > rotate_due) begin
                rotate_due = w.now + {16'd0, cfg_rotate_to};
                if (heading == DIR_LEFT) begin
                  heading  = DIR_RIGHT;
                  c.motion = MOV_RIGHT;
                end else begin
                  heading  = DIR_LEFT;
                  c.motion = MOV_LEFT;
                end
                drop_proximity();
              end
              if (prox_new) begin
                prox_new = 1'b0;
                if (prox_prev > prox_now) begin
                  c.motion  = MOV_STRAIGHT;
                  ctl_state = ST_ESCAPE;
                end
              end
            end
            ST_ESCAPE: begin
              if (prox_new) begin
                prox_new = 1'b0;
                if (prox_prev < prox_now) ctl_state = ST_INIT;
              end
            end
            default: begin
              // Idle and init both pick a fresh direction from the coin.
              if (w.coin) begin
                heading  = DIR_LEFT;
                c.motion = MOV_LEFT;
              end else begin
                heading  = DIR_RIGHT;
                c.motion = MOV_RIGHT;
              end
              drop_proximity();
              rotate_due = w.now + {16'd0, cfg_rotate_to};
              ctl_state  = ST_ROTATE;
            end
          endcase
        end
      end
      FUNC_READING: begin
        wall_live  = 1'b1;
        detect_due = w.now + {16'd0, cfg_detect_to};
        // Each reading is folded under the mode in force when it arrives.
        if (cfg_max_mode) begin
          if ({6'd0, w.reading} > blk_acc) blk_acc = {6'd0, w.reading};
        end else begin
          blk_acc = blk_acc + {6'd0, w.reading};
        end
        blk_cnt = blk_cnt + 7'd1;
        if (blk_cnt >= BlockLen) begin
          prox_prev = prox_now;
          prox_now  = blk_acc;
          blk_acc   = '0;
          blk_cnt   = '0;
          prox_new  = 1'b1;
        end
      end
      FUNC_RESTART: begin
        heading   = DIR_NONE;
        ctl_state = ST_INIT;
      end
      default: ;
    endcase
    c.active = wall_live;
    return c;
  endfunction

  // Driver: offers words from the queue, holding each one until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    sensor_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        w.func    = wac_func_e'(func_i);
        w.now     = now_i;
        w.reading = reading_i;
        w.coin    = coin_i;
        command_q.push_back(next_command(w));
      end
      if (in_valid_i && !in_ready_o) begin
        // The word stays on the port until it is accepted.
      end else if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        w = word_q.pop_front();
        in_valid_i <= 1'b1;
        func_i     <= w.func;
        now_i      <= w.now;
        reading_i  <= w.reading;
        coin_i     <= w.coin;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each taken result against the oldest prediction and
  // drives the result-side ready, including the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    steer_cmd_t  want;
    int unsigned hold_left;
    int unsigned hold_seen;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (command_q.size() == 0) begin
          $error("result word with nothing predicted: active %0d motion %0d",
                 active_o, motion_o);
          mismatches++;
        end else begin
          want = command_q.pop_front();
          if (active_o !== want.active) begin
            $error("active: expected %0d, got %0d", want.active, active_o);
            mismatches++;
          end
          if (motion_o !== want.motion) begin
            $error("motion: expected %0d, got %0d", want.motion, motion_o);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_id) begin
        hold_seen = hold_id;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic void push_word(wac_func_e func, logic [TimeW-1:0] now,
                                    logic [ReadingW-1:0] reading, logic coin);
    sensor_word_t w;
    w.func    = func;
    w.now     = now;
    w.reading = reading;
    w.coin    = coin;
    word_q.push_back(w);
  endfunction

  // Mostly well-formed traffic: readings in blocks around one level, ticks that
  // move a running clock a little, now and then a jump past the timeouts, a
  // restart, or a word of pure noise. The first word is always a reading so
  // that a block left open by the previous phase continues under the new mode.
  function automatic void queue_random_words(int unsigned count);
    int unsigned roll;
    int unsigned lvl;
    int unsigned step;
    for (int unsigned i = 0; i < count; i++) begin
      roll = (i == 0) ? 10 : $urandom_range(99);
      if (roll < 4) begin
        push_word(wac_func_e'($urandom_range(3)), $urandom, 10'($urandom_range(1023)),
                  1'($urandom_range(1)));
      end else if (roll < 7) begin
        push_word(FUNC_RESTART, gen_time, 10'($urandom_range(1023)),
                  1'($urandom_range(1)));
      end else if (roll < 62) begin
        if (gen_reads % BlockLen == 0) gen_level = $urandom_range(1023);
        gen_reads++;
        lvl = gen_level + $urandom_range(12);
        push_word(FUNC_READING, gen_time, (lvl > 1023) ? 10'd1023 : 10'(lvl),
                  1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) < 6) begin
          step = $urandom_range(2 * (cfg_detect_to + cfg_rotate_to) + 8);
        end else begin
          step = $urandom_range(3);
        end
        gen_time = gen_time + step;
        push_word(FUNC_TICK, gen_time, 10'($urandom_range(1023)),
                  1'($urandom_range(1)));
      end
    end
  endfunction

  // Blocks until no word is queued, offered or in flight.
  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || command_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(wac_cfg_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_REDUCE_MODE:    cfg_max_mode  = value[0];
      CFG_DETECT_TIMEOUT: cfg_detect_to = value;
      CFG_ROTATE_TIMEOUT: cfg_rotate_to = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random phase: drain, reprogram, set the idle rates and queue words.
  task automatic run_phase(logic max_mode, logic [CfgDataW-1:0] detect_to,
                           logic [CfgDataW-1:0] rotate_to, int unsigned s_idle,
                           int unsigned r_idle, logic [TimeW-1:0] start_time);
    wait_drained();
    write_reg(CFG_REDUCE_MODE, {15'd0, max_mode});
    write_reg(CFG_DETECT_TIMEOUT, detect_to);
    write_reg(CFG_ROTATE_TIMEOUT, rotate_to);
    @(negedge clk_i);
    send_idle = s_idle;
    recv_idle = r_idle;
    gen_time  = start_time;
    queue_random_words(PhaseWords);
  endtask

  initial begin : limit
    #(ClkPeriod * LimitCycles);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] rnd_detect;
    logic [CfgDataW-1:0] rnd_rotate;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset configuration. A tick before any reading,
    // an ignored func three word at the top of the time range, and a restart
    // that forces init.
    push_word(FUNC_TICK,    32'd0,          10'd0,    1'b0);
    push_word(FUNC_NOP,     32'hFFFF_FFFF,  10'h3FF,  1'b1);
    push_word(FUNC_RESTART, 32'd0,          10'd0,    1'b1);
    // A reading arms detection; the tick then leaves init turning left.
    push_word(FUNC_READING, 32'd100,        10'd1023, 1'b0);
    push_word(FUNC_TICK,    32'd101,        10'd0,    1'b1);
    // A full block at the maximum reading, then a full block of zeros: the
    // proximity falls, so the following tick escapes straight ahead.
    for (int i = 0; i < BlockLen; i++) push_word(FUNC_READING, 32'd102, 10'd1023, 1'b1);
    push_word(FUNC_TICK,    32'd103,        10'd0,    1'b0);
    for (int i = 0; i < BlockLen; i++) push_word(FUNC_READING, 32'd104, 10'd0, 1'b0);
    push_word(FUNC_TICK,    32'd105,        10'd0,    1'b0);
    // The detection deadline wraps past zero, so the next tick drops the wall.
    push_word(FUNC_READING, 32'hFFFF_FFF0,  10'd512,  1'b1);
    push_word(FUNC_TICK,    32'hFFFF_FFF8,  10'd0,    1'b1);

    // Sender idles lightly and the receiver heavily first.
    run_phase(1'b1, 16'd32, 16'd240, 13, 72, 32'd1000);
    run_phase(1'b0, 16'd8,  16'd20,  13, 72, 32'd50000);
    // Long receiver hold while the sender keeps offering, so both internal
    // registers fill and the input side stalls.
    hold_id++;
    // Then the other way round, with the timeouts at their extremes.
    run_phase(1'b1, 16'hFFFF, 16'd0,   72, 13, 32'd0);
    run_phase(1'b0, 16'd0,    16'hFFFF, 72, 13, 32'h8000_0000);
    // Finally no idling; the first of these starts the clock near the top of its range.
    run_phase(1'b1, 16'd3, 16'd6, 0, 0, 32'hFFFF_FF80);
    rnd_detect = 16'($urandom_range(40));
    rnd_rotate = 16'($urandom_range(60));
    run_phase(1'($urandom_range(1)), rnd_detect, rnd_rotate, 0, 0, $urandom);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
